>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// The condition must hold in the cycle after reset is seen.
`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("assertion failed: state after reset");

`endif

>>> hdl/iirdf1_pkg.sv
`timescale 1ns / 1ps

package iirdf1_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_WIDTH      = 18;
   localparam int FRAC_BITS       = 14;
   localparam int ORDER_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH = 3;

   // A 16 x 18 product, and headroom for the sum of five of them.
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 3;
   localparam int QUOT_WIDTH = ACC_WIDTH - FRAC_BITS;

   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = 1;
   localparam int QUEUE_COUNT_WIDTH = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_ORDER  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUMERATOR_0   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUMERATOR_1   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUMERATOR_2   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DENOMINATOR_1 = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DENOMINATOR_2 = 3'd5;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;
   typedef logic signed [QUOT_WIDTH-1:0]   quot_type;

   localparam sample_type SAMPLE_MAX = 16'sh7FFF;
   localparam sample_type SAMPLE_MIN = 16'sh8000;
   localparam acc_type    ROUND_HALF = acc_type'(longint'(1) << (FRAC_BITS - 1));

   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 2'd2;
   localparam coef_type               UNITY_COEF  = 18'sd16384;

   typedef struct packed {
      logic [ORDER_WIDTH-1:0] filter_order;
      coef_type               numerator_0;
      coef_type               numerator_1;
      coef_type               numerator_2;
      coef_type               denominator_1;
      coef_type               denominator_2;
   } csr_type;

   typedef struct packed {
      acc_type feed_forward;
      logic    clear;
   } mid_type;

   typedef struct packed {
      sample_type filtered;
      logic       saturated;
   } rsp_type;

   // Order 0 behaves as first order and order 3 as second order.
   function automatic logic second_order(input logic [ORDER_WIDTH-1:0] order);
      return order[1];
   endfunction

endpackage

>>> hdl/iir_direct_form_one_filter.sv
`timescale 1ns / 1ps
// Channel   Direction  Beat moves on                 Payload
// req       in         req_push & !req_full          req_sample, req_clear
// rsp       out        rsp_pop & !rsp_empty          rsp_filtered, rsp_saturated
// csr       in         csr_valid & csr_ready         csr_index, csr_data
//
// One sample can be taken every cycle while req_full is low. A result is registered in the
// middle queue and then in the result buffer before it reaches the rsp ports.
// The rate is set by the output feedback loop, which closes in the back end.
// Reset is synchronous: it empties both queues, zeroes the histories and loads the
// default coefficients (unity pass-through, second order).
// A stalled result side fills the result buffer and then the middle queue, which raises req_full.

module iir_direct_form_one_filter (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_push,
   output logic                                       req_full,
   input  iirdf1_pkg::sample_type                     req_sample,
   input  logic                                       req_clear,
   output logic                                       rsp_empty,
   input  logic                                       rsp_pop,
   output iirdf1_pkg::sample_type                     rsp_filtered,
   output logic                                       rsp_saturated,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [iirdf1_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  iirdf1_pkg::coef_type                       csr_data
);
   import iirdf1_pkg::*;

   // Coefficient and order registers. A write needs no wait state, so the
   // port is always ready; indexes past the last register are dropped.
   csr_type csr_ff, csr_in;
   logic    csr_write;

   // Front end to back end.
   logic    mid_push, mid_full, mid_pop, mid_empty;
   mid_type mid_push_data, mid_pop_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FILTER_ORDER:  csr_in.filter_order  = csr_data[ORDER_WIDTH-1:0];
            CSR_NUMERATOR_0:   csr_in.numerator_0   = csr_data;
            CSR_NUMERATOR_1:   csr_in.numerator_1   = csr_data;
            CSR_NUMERATOR_2:   csr_in.numerator_2   = csr_data;
            CSR_DENOMINATOR_1: csr_in.denominator_1 = csr_data;
            CSR_DENOMINATOR_2: csr_in.denominator_2 = csr_data;
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.filter_order  <= ORDER_RESET;
         csr_ff.numerator_0   <= UNITY_COEF;
         csr_ff.numerator_1   <= '0;
         csr_ff.numerator_2   <= '0;
         csr_ff.denominator_1 <= '0;
         csr_ff.denominator_2 <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // The front end applies the clear bit to the input history and forms the
   // feed-forward sum as the sample arrives.
   iirdf1_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_sample (req_sample),
      .req_clear  (req_clear),
      .csr        (csr_ff),
      .mid_push   (mid_push),
      .mid_data   (mid_push_data),
      .mid_full   (mid_full)
   );

   // The middle queue lets the front keep accepting while the back end waits
   // on a full result buffer.
   iirdf1_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   // The back end closes the output feedback loop, rounds, saturates and
   // buffers the result.
   iirdf1_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ff),
      .mid_empty     (mid_empty),
      .mid_data      (mid_pop_data),
      .mid_pop       (mid_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_filtered  (rsp_filtered),
      .rsp_saturated (rsp_saturated)
   );

endmodule

>>> hdl/iirdf1_front.sv
`timescale 1ns / 1ps

module iirdf1_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  iirdf1_pkg::sample_type req_sample,
   input  logic                  req_clear,
   input  iirdf1_pkg::csr_type    csr,
   output logic                  mid_push,
   output iirdf1_pkg::mid_type    mid_data,
   input  logic                  mid_full
);
   import iirdf1_pkg::*;

   sample_type x1_ff, x1_in, x2_ff, x2_in;
   sample_type x1_eff, x2_eff;
   prod_type   prod_0, prod_1, prod_2;
   logic       accept;
   logic       second;

   assign req_full = mid_full;
   assign accept   = req_push & ~mid_full;
   assign mid_push = accept;
   assign second   = second_order(csr.filter_order);

   // The feed-forward half of the filter needs only the input history,
   // so it is finished here and handed on as one partial sum.
   always_comb begin
      x1_eff = req_clear ? '0 : x1_ff;
      x2_eff = req_clear ? '0 : x2_ff;
      prod_0 = req_sample * csr.numerator_0;
      prod_1 = x1_eff * csr.numerator_1;
      prod_2 = x2_eff * csr.numerator_2;
      if (!second) begin
         prod_2 = '0;
      end
      mid_data.feed_forward = ACC_WIDTH'(prod_0) + ACC_WIDTH'(prod_1) + ACC_WIDTH'(prod_2);
      mid_data.clear        = req_clear;
   end

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      if (accept) begin
         x1_in = req_sample;
         x2_in = second ? x1_eff : x2_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
      end
   end

endmodule

>>> hdl/iirdf1_queue.sv
`timescale 1ns / 1ps

module iirdf1_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  iirdf1_pkg::mid_type push_data,
   output logic                full,
   input  logic                pop,
   output iirdf1_pkg::mid_type pop_data,
   output logic                empty
);
   import iirdf1_pkg::*;

   mid_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign full     = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/iirdf1_back.sv
`timescale 1ns / 1ps

module iirdf1_back (
   input  logic                   clock,
   input  logic                   reset,
   input  iirdf1_pkg::csr_type     csr,
   input  logic                   mid_empty,
   input  iirdf1_pkg::mid_type     mid_data,
   output logic                   mid_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output iirdf1_pkg::sample_type rsp_filtered,
   output logic                   rsp_saturated
);
   import iirdf1_pkg::*;

   localparam quot_type QUOT_MAX = QUOT_WIDTH'(SAMPLE_MAX);
   localparam quot_type QUOT_MIN = QUOT_WIDTH'(SAMPLE_MIN);

   sample_type y1_ff, y1_in, y2_ff, y2_in;
   sample_type y1_eff, y2_eff;
   prod_type   prod_1, prod_2;
   acc_type    acc_sum;
   quot_type   quot;
   rsp_type    result;
   logic       second;

   rsp_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         out_full, do_pop;

   assign second  = second_order(csr.filter_order);
   assign out_full = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign mid_pop = ~mid_empty & ~out_full;

   // Feedback half, round half up, floor shift, and clip to 16 bits.
   always_comb begin
      y1_eff  = mid_data.clear ? '0 : y1_ff;
      y2_eff  = mid_data.clear ? '0 : y2_ff;
      prod_1  = y1_eff * csr.denominator_1;
      prod_2  = y2_eff * csr.denominator_2;
      if (!second) begin
         prod_2 = '0;
      end
      acc_sum = mid_data.feed_forward - ACC_WIDTH'(prod_1) - ACC_WIDTH'(prod_2) + ROUND_HALF;
      quot    = acc_sum[ACC_WIDTH-1:FRAC_BITS];
      if (quot > QUOT_MAX) begin
         result.filtered  = SAMPLE_MAX;
         result.saturated = 1'b1;
      end else if (quot < QUOT_MIN) begin
         result.filtered  = SAMPLE_MIN;
         result.saturated = 1'b1;
      end else begin
         result.filtered  = quot[SAMPLE_WIDTH-1:0];
         result.saturated = 1'b0;
      end
   end

   always_comb begin
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (mid_pop) begin
         y1_in = result.filtered;
         y2_in = second ? y1_eff : y2_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

   // Two-entry result buffer so the back end keeps going while a result waits.
   assign rsp_empty     = (count_ff == '0);
   assign do_pop        = rsp_pop & ~rsp_empty;
   assign rsp_filtered  = entry_ff[rd_ptr_ff].filtered;
   assign rsp_saturated = entry_ff[rd_ptr_ff].saturated;

   always_comb begin
      wr_ptr_in = mid_pop ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (mid_pop && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !mid_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         entry_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

>>> hdl/iirdf1_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iirdf1_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input iirdf1_pkg::sample_type rsp_filtered,
   input logic                   rsp_saturated
);
   import iirdf1_pkg::*;

   logic rsp_waiting;
   logic rsp_clipped;
   logic on_rail;

   assign rsp_waiting = !rsp_empty && !rsp_pop;
   assign rsp_clipped = !rsp_empty && rsp_saturated;
   assign on_rail     = (rsp_filtered == SAMPLE_MAX) || (rsp_filtered == SAMPLE_MIN);

   // Both queues come out of reset empty.
   `ASSERT_AFTER_RESET(a_reset_empty, clock, reset, rsp_empty && !req_full)

   // A waiting result does not vanish before it is popped.
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_waiting, !rsp_empty)

   // A waiting result keeps its value while it is not popped.
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_waiting, $stable({rsp_filtered, rsp_saturated}))

   // A clipped result sits on one of the two rails.
   `ASSERT_IMPLY(a_sat_rail, clock, reset, rsp_clipped, on_rail)

endmodule

bind iir_direct_form_one_filter iirdf1_checker u_checker (.*);
